### rtl/sov_pkg.sv
// ----------------------------------------------------------------------------
// sov_pkg: shared types, constants and tables of the sine oscillator
//
// Phase and table geometry, fixed-point constants, the controller state
// encoding, the command and status bundles and the two constant tables.
// ----------------------------------------------------------------------------
package sov_pkg;

  localparam int PHASE_BITS      = 32;
  localparam int SINE_TABLE_BITS = 8;
  localparam int BEND_TABLE_BITS = 8;

  localparam int SINE_N = 1 << SINE_TABLE_BITS;
  localparam int BEND_N = 1 << BEND_TABLE_BITS;

  localparam int INC_W    = 32;
  localparam int DEPTH_W  = 12;
  localparam int LEVEL_W  = 8;
  localparam int SINE_W   = 16;
  localparam int MAG_W    = 15;
  localparam int BEND_W   = 18;
  localparam int FACTOR_W = 18;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 4;

  localparam logic [DEPTH_W-1:0] MAX_DEPTH = DEPTH_W'(2400);
  localparam logic [SINE_W-1:0]  SINE_FULL = SINE_W'(32767);
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(250);

  // Octave offset: floor(|lfo|*depth*4096 / 2457525), by reciprocal multiply
  localparam int PROD_W      = MAG_W + DEPTH_W;
  localparam int NUM_SHIFT   = 12;
  localparam int DIV_W       = 22;
  localparam int QUO_W       = 18;
  localparam int REM_W       = 23;
  localparam int RECIP_W     = 31;
  localparam int RECIP_SHIFT = 40;
  localparam int NUM_W       = PROD_W + NUM_SHIFT;
  localparam int QD_W        = QUO_W + DIV_W;
  localparam int MAGO_W      = QUO_W + 1;
  localparam int OCT_W       = MAGO_W + 1;
  localparam int U_W         = 19;
  localparam int SHIFT_W     = 3;
  localparam int FSH_W       = BEND_W + 8;

  localparam logic [DIV_W-1:0]   BEND_DIV = DIV_W'(2457525);
  localparam logic [63:0]        BEND_RECIP_FULL =
    (64'd1 << (RECIP_SHIFT + NUM_SHIFT)) / 64'd2457525;
  localparam logic [RECIP_W-1:0] BEND_RECIP = BEND_RECIP_FULL[RECIP_W-1:0];
  localparam logic [OCT_W-1:0]   OCT_BIAS   = OCT_W'(3 << 16);
  localparam logic [FSH_W-1:0]   FACTOR_MAX = FSH_W'(18'h3FFFF);
  localparam int                 FRAC_LSB   = 16;

  // Output level: floor(w*125/32767) with w = sine + 32767
  localparam int LVL_W      = 16;
  localparam int LVL_PROD_W = 23;
  localparam int LVL_SHIFT  = 15;
  localparam logic [LVL_PROD_W-1:0] LVL_SCALE = LVL_PROD_W'(125);
  localparam logic [LVL_W-1:0]      LVL_DIV   = LVL_W'(32767);

  typedef enum logic [1:0] {
    REG_NOTE_INC  = 2'd0,
    REG_VIB_INC   = 2'd1,
    REG_VIB_DEPTH = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LFO,
    S_MUL_DEPTH,
    S_MUL_RECIP,
    S_MUL_REM,
    S_CORR,
    S_FACTOR,
    S_BEND,
    S_STEP,
    S_TONE,
    S_SCALE,
    S_LEVEL
  } sov_state_t;

  typedef struct packed {
    logic lfo_sine;
    logic mul_depth;
    logic mul_recip;
    logic mul_rem;
    logic corr;
    logic factor;
    logic bend;
    logic step;
    logic tone;
    logic scale;
    logic load_out;
  } sov_cmd_t;

  typedef struct packed {
    logic vib_on;
    logic out_busy;
  } sov_stat_t;

  typedef logic [SINE_W-1:0] sine_tab_t [SINE_N];
  typedef logic [BEND_W-1:0] bend_tab_t [BEND_N];

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] LN2_Q30     = 64'd744261118;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  // Taylor series of sin, evaluated at elaboration
  function automatic logic [SINE_W-1:0] series_sine(input int unsigned i);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] s;
    logic [63:0] r;
    longint      sum;
    int unsigned k;
    x    = (HALF_PI_Q30 * 64'(i)) >> SINE_TABLE_BITS;
    term = x;
    sum  = longint'(x);
    for (k = 1; k <= 10; k++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if ((k & 1) != 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    s = (sum > 0) ? 64'(sum) : 64'd0;
    r = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    return (r > 64'd32767) ? SINE_FULL : r[SINE_W-1:0];
  endfunction

  // Taylor series of exp(y*ln2), evaluated at elaboration
  function automatic logic [BEND_W-1:0] series_exp2(input int unsigned j);
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    int unsigned k;
    y    = (LN2_Q30 * 64'(j)) >> BEND_TABLE_BITS;
    term = ONE_Q30;
    sum  = ONE_Q30;
    for (k = 1; k <= 14; k++) begin
      term = ((term * y) >> 30) / 64'(k);
      sum  = sum + term;
    end
    r = (sum + (64'd1 << 13)) >> 14;
    return r[BEND_W-1:0];
  endfunction

  function automatic sine_tab_t gen_sine_tab();
    sine_tab_t t;
    for (int i = 0; i < SINE_N; i++) begin
      t[i] = series_sine(i);
    end
    return t;
  endfunction

  function automatic bend_tab_t gen_bend_tab();
    bend_tab_t t;
    for (int i = 0; i < BEND_N; i++) begin
      t[i] = series_exp2(i);
    end
    return t;
  endfunction

  localparam sine_tab_t SINE_TAB = gen_sine_tab();
  localparam bend_tab_t BEND_TAB = gen_bend_tab();

endpackage

### rtl/sov_ctrl.sv
// ----------------------------------------------------------------------------
// sov_ctrl: sequencer of the sine oscillator
//
// Takes one tick word at a time and walks the datapath through the vibrato
// bend, the phase step, the sine lookup and the level scaling.
// ----------------------------------------------------------------------------
module sov_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_tick,
  input  sov_pkg::sov_stat_t stat,
  output sov_pkg::sov_cmd_t  cmd
);

  sov_pkg::sov_state_t state_r;
  sov_pkg::sov_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sov_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sov_pkg::S_IDLE: begin
        // a word with tick low is taken and dropped
        if (in_valid && in_tick) begin
          state_nxt = stat.vib_on ? sov_pkg::S_LFO : sov_pkg::S_STEP;
        end
      end
      sov_pkg::S_LFO:       state_nxt = sov_pkg::S_MUL_DEPTH;
      sov_pkg::S_MUL_DEPTH: state_nxt = sov_pkg::S_MUL_RECIP;
      sov_pkg::S_MUL_RECIP: state_nxt = sov_pkg::S_MUL_REM;
      sov_pkg::S_MUL_REM:   state_nxt = sov_pkg::S_CORR;
      sov_pkg::S_CORR:      state_nxt = sov_pkg::S_FACTOR;
      sov_pkg::S_FACTOR:    state_nxt = sov_pkg::S_BEND;
      sov_pkg::S_BEND:      state_nxt = sov_pkg::S_STEP;
      sov_pkg::S_STEP:      state_nxt = sov_pkg::S_TONE;
      sov_pkg::S_TONE:      state_nxt = sov_pkg::S_SCALE;
      sov_pkg::S_SCALE:     state_nxt = sov_pkg::S_LEVEL;
      sov_pkg::S_LEVEL: begin
        // hold until the output register is free
        if (!stat.out_busy) begin
          state_nxt = sov_pkg::S_IDLE;
        end
      end
      default:              state_nxt = sov_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    in_ready     = 1'b0;
    case (state_r)
      sov_pkg::S_IDLE:      in_ready      = 1'b1;
      sov_pkg::S_LFO:       cmd.lfo_sine  = 1'b1;
      sov_pkg::S_MUL_DEPTH: cmd.mul_depth = 1'b1;
      sov_pkg::S_MUL_RECIP: cmd.mul_recip = 1'b1;
      sov_pkg::S_MUL_REM:   cmd.mul_rem   = 1'b1;
      sov_pkg::S_CORR:      cmd.corr      = 1'b1;
      sov_pkg::S_FACTOR:    cmd.factor    = 1'b1;
      sov_pkg::S_BEND:      cmd.bend      = 1'b1;
      sov_pkg::S_STEP:      cmd.step      = 1'b1;
      sov_pkg::S_TONE:      cmd.tone      = 1'b1;
      sov_pkg::S_SCALE:     cmd.scale     = 1'b1;
      sov_pkg::S_LEVEL:     cmd.load_out  = !stat.out_busy;
      default:              in_ready      = 1'b0;
    endcase
  end

endmodule

### rtl/sov_datapath.sv
// ----------------------------------------------------------------------------
// sov_datapath: phase accumulators, vibrato bend and level scaling
//
// Holds both phases, one shared sine lookup, the octave-offset reciprocal
// divider, the bend multiply and the output register.
// ----------------------------------------------------------------------------
module sov_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sov_pkg::sov_cmd_t             cmd,
  output sov_pkg::sov_stat_t            stat,
  input  logic [sov_pkg::INC_W-1:0]     note_inc,
  input  logic [sov_pkg::INC_W-1:0]     vib_inc,
  input  logic [sov_pkg::DEPTH_W-1:0]   depth,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sov_pkg::LEVEL_W-1:0]   out_level
);

  localparam int PB = sov_pkg::PHASE_BITS;
  localparam int SB = sov_pkg::SINE_TABLE_BITS;
  localparam int BB = sov_pkg::BEND_TABLE_BITS;

  logic [PB-1:0]                    tone_phase_r;
  logic [PB-1:0]                    lfo_phase_r;
  logic signed [sov_pkg::SINE_W-1:0] sin_r;
  logic [sov_pkg::PROD_W-1:0]       prod_r;
  logic                             neg_r;
  logic [sov_pkg::QUO_W-1:0]        qest_r;
  logic [sov_pkg::REM_W-1:0]        rem_r;
  logic [sov_pkg::QUO_W-1:0]        quo_r;
  logic                             nz_r;
  logic [sov_pkg::FACTOR_W-1:0]     factor_r;
  logic [PB-1:0]                    binc_r;
  logic [sov_pkg::LVL_PROD_W-1:0]   lvl_prod_r;
  logic [sov_pkg::LEVEL_W-1:0]      level_r;
  logic                             out_valid_r;

  logic [PB-1:0] inc;
  logic [PB-1:0] vinc;
  assign inc  = note_inc[PB-1:0];
  assign vinc = vib_inc[PB-1:0];

  assign stat.vib_on   = (vinc != '0);
  assign stat.out_busy = out_valid_r && !out_ready;

  // Shared quarter-wave sine lookup
  logic [PB-1:0]                     sp;
  logic [1:0]                        quad;
  logic [SB-1:0]                     sidx;
  logic [SB-1:0]                     sidx_m;
  logic [sov_pkg::SINE_W-1:0]        smag;
  logic signed [sov_pkg::SINE_W-1:0] sval;

  always_comb begin
    sp     = cmd.tone ? tone_phase_r : lfo_phase_r;
    quad   = sp[PB-1 -: 2];
    sidx   = sp[PB-3 -: SB];
    sidx_m = SB'(0) - sidx;
    if (quad[0]) begin
      smag = (sidx == '0) ? sov_pkg::SINE_FULL : sov_pkg::SINE_TAB[sidx_m];
    end else begin
      smag = sov_pkg::SINE_TAB[sidx];
    end
    sval = quad[1] ? -$signed(smag) : $signed(smag);
  end

  // Depth times sine magnitude
  logic [sov_pkg::DEPTH_W-1:0] depth_sat;
  logic [sov_pkg::SINE_W-1:0]  sin_abs;
  logic [sov_pkg::MAG_W-1:0]   sin_mag;

  always_comb begin
    depth_sat = (depth > sov_pkg::MAX_DEPTH) ? sov_pkg::MAX_DEPTH : depth;
    sin_abs   = sin_r[sov_pkg::SINE_W-1] ? 16'(-sin_r) : 16'(sin_r);
    sin_mag   = sin_abs[sov_pkg::MAG_W-1:0];
  end

  // Quotient estimate and remainder; the estimate is exact or one low
  logic [sov_pkg::PROD_W+sov_pkg::RECIP_W-1:0] recip_prod;
  logic [sov_pkg::NUM_W-1:0]                   num_sh;
  logic [sov_pkg::QD_W-1:0]                    qd;
  logic [sov_pkg::QD_W-1:0]                    rem_full;
  logic [sov_pkg::REM_W-1:0]                   rem_adj;
  logic                                        rem_ge;

  always_comb begin
    recip_prod = (sov_pkg::PROD_W+sov_pkg::RECIP_W)'(prod_r) *
                 (sov_pkg::PROD_W+sov_pkg::RECIP_W)'(sov_pkg::BEND_RECIP);
    num_sh     = {prod_r, sov_pkg::NUM_SHIFT'(0)};
    qd         = sov_pkg::QD_W'(qest_r) * sov_pkg::QD_W'(sov_pkg::BEND_DIV);
    rem_full   = sov_pkg::QD_W'(num_sh) - qd;
    rem_ge     = (rem_r >= sov_pkg::REM_W'(sov_pkg::BEND_DIV));
    rem_adj    = rem_r - sov_pkg::REM_W'(sov_pkg::BEND_DIV);
  end

  // Octave offset to bend factor
  logic [sov_pkg::MAGO_W-1:0]  oct_mag;
  logic [sov_pkg::OCT_W-1:0]   oct;
  logic [sov_pkg::OCT_W-1:0]   u_full;
  logic [sov_pkg::SHIFT_W-1:0] oct_shift;
  logic [BB-1:0]               bidx;
  logic [sov_pkg::FSH_W-1:0]   fsh;

  always_comb begin
    oct_mag   = sov_pkg::MAGO_W'(quo_r) + sov_pkg::MAGO_W'(neg_r && nz_r);
    oct       = neg_r ? (sov_pkg::OCT_W'(0) - sov_pkg::OCT_W'(oct_mag))
                      : sov_pkg::OCT_W'(oct_mag);
    u_full    = sov_pkg::OCT_BIAS + oct;
    oct_shift = u_full[sov_pkg::FRAC_LSB +: sov_pkg::SHIFT_W];
    bidx      = u_full[sov_pkg::FRAC_LSB-1 -: BB];
    fsh       = (sov_pkg::FSH_W'(sov_pkg::BEND_TAB[bidx]) << oct_shift) >> 3;
  end

  // Bent increment
  logic [PB+sov_pkg::FACTOR_W-1:0] bprod;
  assign bprod = (PB+sov_pkg::FACTOR_W)'(inc) * (PB+sov_pkg::FACTOR_W)'(factor_r);

  // Level: x/32767 as x>>15 plus one correction step
  logic [sov_pkg::LVL_W:0]     w_ext;
  logic [sov_pkg::LEVEL_W-1:0] q0;
  logic [sov_pkg::LVL_W-1:0]   lrem;
  logic [sov_pkg::LEVEL_W-1:0] level_nxt;

  always_comb begin
    w_ext     = (sov_pkg::LVL_W+1)'(sin_r) + (sov_pkg::LVL_W+1)'(sov_pkg::LVL_DIV);
    q0        = lvl_prod_r[sov_pkg::LVL_SHIFT +: sov_pkg::LEVEL_W];
    lrem      = sov_pkg::LVL_W'(lvl_prod_r[sov_pkg::LVL_SHIFT-1:0]) + sov_pkg::LVL_W'(q0);
    level_nxt = q0 + sov_pkg::LEVEL_W'(lrem >= sov_pkg::LVL_DIV);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_phase_r <= '0;
      lfo_phase_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.step) begin
        tone_phase_r <= tone_phase_r + (stat.vib_on ? binc_r : inc);
        lfo_phase_r  <= lfo_phase_r + vinc;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lfo_sine || cmd.tone) begin
      sin_r <= sval;
    end
    if (cmd.mul_depth) begin
      prod_r <= sov_pkg::PROD_W'(sin_mag) * sov_pkg::PROD_W'(depth_sat);
      neg_r  <= sin_r[sov_pkg::SINE_W-1];
    end
    if (cmd.mul_recip) begin
      qest_r <= recip_prod[sov_pkg::RECIP_SHIFT +: sov_pkg::QUO_W];
    end
    if (cmd.mul_rem) begin
      rem_r <= rem_full[sov_pkg::REM_W-1:0];
    end
    if (cmd.corr) begin
      quo_r <= rem_ge ? (qest_r + sov_pkg::QUO_W'(1)) : qest_r;
      nz_r  <= rem_ge ? (rem_adj != '0) : (rem_r != '0);
    end
    if (cmd.factor) begin
      factor_r <= (fsh > sov_pkg::FACTOR_MAX) ? sov_pkg::FACTOR_MAX[sov_pkg::FACTOR_W-1:0]
                                              : fsh[sov_pkg::FACTOR_W-1:0];
    end
    if (cmd.bend) begin
      binc_r <= bprod[sov_pkg::FRAC_LSB +: PB];
    end
    if (cmd.scale) begin
      lvl_prod_r <= sov_pkg::LVL_PROD_W'(w_ext[sov_pkg::LVL_W-1:0]) * sov_pkg::LVL_SCALE;
    end
    if (cmd.load_out) begin
      level_r <= level_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_level = level_r;

endmodule

### rtl/sine_oscillator_with_vibrato.sv
// ----------------------------------------------------------------------------
// sine_oscillator_with_vibrato: DDS tone generator with sine vibrato
//
// Input channel (in_valid/in_ready/in_tick): one word per sample period.
// A word with in_tick high yields one out_level word; a word with in_tick
// low is taken and dropped with no change of phase.
// Output channel (out_valid/out_ready/out_level): PWM level 0..250, held in
// an output register until taken.
// The sequencer handles one tick at a time and takes no new word until the
// last has loaded its level. With vibrato on the steps are the LFO lookup,
// depth multiply, reciprocal divide, bend multiply, phase add, lookup and
// level scaling; with vibrato_increment zero they start at the phase add.
// A stalled receiver holds the finished level; the next tick is accepted
// and worked on meanwhile, and its last step waits for the register.
// Reset clears both phases and the three configuration registers.
// Configuration: APB writes at 0x0 note increment, 0x4 vibrato increment,
// 0x8 vibrato depth in cents; write only while no tick is in flight.
// ----------------------------------------------------------------------------
module sine_oscillator_with_vibrato (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_tick,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sov_pkg::LEVEL_W-1:0] out_level,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sov_pkg::ADDR_W-1:0]  paddr,
  input  logic [sov_pkg::DATA_W-1:0]  pwdata,
  output logic [sov_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  logic [sov_pkg::INC_W-1:0]   note_inc_r;
  logic [sov_pkg::INC_W-1:0]   vib_inc_r;
  logic [sov_pkg::DEPTH_W-1:0] depth_r;

  sov_pkg::reg_idx_t  reg_idx;
  logic               wr_en;
  sov_pkg::sov_cmd_t  cmd;
  sov_pkg::sov_stat_t stat;

  assign pready  = 1'b1;
  assign reg_idx = sov_pkg::reg_idx_t'(paddr[sov_pkg::ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      note_inc_r <= '0;
      vib_inc_r  <= '0;
      depth_r    <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        sov_pkg::REG_NOTE_INC:  note_inc_r <= pwdata;
        sov_pkg::REG_VIB_INC:   vib_inc_r  <= pwdata;
        sov_pkg::REG_VIB_DEPTH: depth_r    <= pwdata[sov_pkg::DEPTH_W-1:0];
        default:                depth_r    <= depth_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      sov_pkg::REG_NOTE_INC:  prdata = note_inc_r;
      sov_pkg::REG_VIB_INC:   prdata = vib_inc_r;
      sov_pkg::REG_VIB_DEPTH: prdata = sov_pkg::DATA_W'(depth_r);
      default:                prdata = '0;
    endcase
  end

  sov_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_tick  (in_tick),
    .stat     (stat),
    .cmd      (cmd)
  );

  sov_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .note_inc  (note_inc_r),
    .vib_inc   (vib_inc_r),
    .depth     (depth_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_level (out_level)
  );

`ifndef SYNTHESIS
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_level <= sov_pkg::LEVEL_MAX))
    else $error("level out of range");

  a_idle_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_tick) |=> in_ready)
    else $error("word without tick started work");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_tick) |=> !in_ready)
    else $error("tick accepted without starting work");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while sequencer idle");
`endif

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the sine oscillator with vibrato
//
// Sends tick words with random gaps and takes the levels with random stalls.
// A scripted opening covers reset state, quarter-turn steps, depth limits,
// bend saturation and an unmapped register write. Random phases follow, each with
// new register values. Levels the opening does not fix are checked against
// an in-bench fixed-point model of the phase accumulators, the sine lookup and bend.
// ----------------------------------------------------------------------------
module tb;

  localparam int          WORD_TARGET  = 1550;
  localparam int          WATCHDOG_MAX = 2000;
  localparam int          SETTLE_CYC   = 16;
  localparam int          DEPTH_CAP    = 2400;
  localparam int          HOLD_CYC     = 400;
  localparam logic [1:0]  UNMAPPED_REG = 2'd3;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_WORD
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  sel;
    logic [31:0] data;
    logic        tick;
    logic        typed;
    logic [7:0]  level;
  } row_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic                        in_tick;
  logic                        out_valid;
  logic                        out_ready;
  logic [sov_pkg::LEVEL_W-1:0] out_level;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [sov_pkg::ADDR_W-1:0]  paddr;
  logic [sov_pkg::DATA_W-1:0]  pwdata;
  logic [sov_pkg::DATA_W-1:0]  prdata;
  logic                        pready;

  // model state and register copies
  logic [31:0] tone_ph;
  logic [31:0] lfo_ph;
  logic [31:0] note_inc;
  logic [31:0] vib_inc;
  logic [11:0] vib_depth;
  logic [15:0] sine_lut [256];
  logic [17:0] bend_lut [256];

  logic [7:0]  expected_levels [$];
  row_t        script [$];
  int          errors       = 0;
  int          stall_cycles = 0;
  // the sender bumps hold_seq to ask for a hold; the receiver tracks hold_ack
  int          hold_len     = 0;
  int          hold_seq     = 0;
  int          hold_ack     = 0;
  int          hold_left    = 0;
  bit          idle_on;

  sine_oscillator_with_vibrato dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_tick   (in_tick),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_level (out_level),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // quarter-wave entry i: 32767*sin(pi/2*i/256) by Taylor series in Q30
  function automatic logic [15:0] quarter_sine(input int unsigned i);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] s;
    logic [63:0] r;
    longint      acc;
    x    = (64'd1686629713 * 64'(i)) >> 8;
    term = x;
    acc  = longint'(x);
    for (int k = 1; k <= 10; k++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      acc  = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
    end
    s = (acc > 0) ? 64'(acc) : 64'd0;
    r = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    return (r > 64'd32767) ? 16'd32767 : r[15:0];
  endfunction

  // bend entry j: 65536*2^(j/256) by series of exp(y*ln2) in Q30
  function automatic logic [17:0] octave_frac(input int unsigned j);
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    y    = (64'd744261118 * 64'(j)) >> 8;
    term = 64'd1 << 30;
    sum  = term;
    for (int k = 1; k <= 14; k++) begin
      term = ((term * y) >> 30) / 64'(k);
      sum  = sum + term;
    end
    r = (sum + (64'd1 << 13)) >> 14;
    return r[17:0];
  endfunction

  function automatic int sine_at(input logic [31:0] p);
    logic [7:0] k;
    logic [7:0] mirror;
    int         m;
    k      = p[29:22];
    mirror = 8'd0 - k;
    if (p[30]) begin
      m = (k == 8'd0) ? 32767 : int'(sine_lut[mirror]);
    end else begin
      m = int'(sine_lut[k]);
    end
    return p[31] ? -m : m;
  endfunction

  // Q2.16 pitch factor 2^(lfo*cents/1200), octave offset floored
  function automatic logic [17:0] pitch_factor(input int lfo, input int cents);
    longint      num;
    longint      den;
    longint      oct;
    longint      u;
    logic [63:0] f;
    int          sh;
    int          j;
    num = longint'(lfo) * longint'(cents) * 65536;
    den = 39320400;
    oct = (num >= 0) ? num / den : -((-num + den - 1) / den);
    u   = oct + 196608;
    sh  = int'((u >> 16) & 7);
    j   = int'((u >> 8) & 255);
    f   = (64'(bend_lut[j]) << sh) >> 3;
    return (f > 64'h3FFFF) ? 18'h3FFFF : f[17:0];
  endfunction

  function automatic logic [7:0] next_level();
    logic [63:0] step;
    int          cents;
    int          v;
    step = 64'(note_inc);
    if (vib_inc != 32'd0) begin
      cents = (int'(vib_depth) > DEPTH_CAP) ? DEPTH_CAP : int'(vib_depth);
      step  = ((step * 64'(pitch_factor(sine_at(lfo_ph), cents))) >> 16) & 64'hFFFF_FFFF;
    end
    tone_ph = tone_ph + step[31:0];
    lfo_ph  = lfo_ph + vib_inc;
    v       = sine_at(tone_ph);
    return 8'((v + 32767) * 125 / 32767);
  endfunction

  function automatic bit gap_now();
    return idle_on && ($urandom_range(99) < 22);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic plan_cfg(input logic [1:0] sel, input logic [31:0] data);
    script.push_back('{ROW_CFG, sel, data, 1'b0, 1'b0, 8'd0});
  endtask

  task automatic plan_word(input logic tick, input logic typed, input logic [7:0] level);
    script.push_back('{ROW_WORD, 2'd0, 32'd0, tick, typed, level});
  endtask

  // offer one word, record its level once taken
  task automatic put_word(input logic tick, input logic typed, input logic [7:0] level);
    logic [7:0] lvl;
    while (gap_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_tick  <= tick;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    if (tick) begin
      lvl = next_level();
      expected_levels.push_back(typed ? level : lvl);
    end
  endtask

  // drop valid, drain every level, then let the sequencer finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_levels.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] sel, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= sov_pkg::ADDR_W'({sel, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    case (sel)
      sov_pkg::REG_NOTE_INC:  note_inc  = value;
      sov_pkg::REG_VIB_INC:   vib_inc   = value;
      sov_pkg::REG_VIB_DEPTH: vib_depth = value[11:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // result side: check, then pick next ready
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_levels.size() == 0) begin
        report_mismatch($sformatf("level %0d with nothing expected", out_level));
      end else if (out_level !== expected_levels[0]) begin
        report_mismatch($sformatf("level %0d, expected %0d", out_level,
                                  expected_levels.pop_front()));
      end else begin
        void'(expected_levels.pop_front());
      end
    end
    if (hold_seq != hold_ack) begin
      hold_left = hold_len;
      hold_ack  = hold_seq;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !gap_now();
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= WATCHDOG_MAX) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    int          phase;
    int          words_done;
    int          count;
    logic        tick;
    logic [31:0] junk;
    logic [31:0] value;
    logic [11:0] cents;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_tick   = 1'b0;
    out_ready = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    idle_on      = 1'b1;
    tone_ph   = '0;
    lfo_ph    = '0;
    note_inc  = '0;
    vib_inc   = '0;
    vib_depth = '0;
    for (int i = 0; i < 256; i++) begin
      sine_lut[i] = quarter_sine(i);
      bend_lut[i] = octave_frac(i);
    end

    // reset state, then quarter turns walk the four quadrant edges
    plan_word(1'b1, 1'b1, 8'd125);
    plan_word(1'b0, 1'b0, 8'd0);
    plan_cfg(sov_pkg::REG_NOTE_INC, 32'h4000_0000);
    plan_word(1'b1, 1'b1, 8'd250);
    plan_word(1'b1, 1'b1, 8'd125);
    plan_word(1'b1, 1'b1, 8'd0);
    plan_word(1'b0, 1'b0, 8'd0);
    plan_word(1'b1, 1'b1, 8'd125);
    plan_cfg(sov_pkg::REG_NOTE_INC, 32'hFFFF_FFFF);
    plan_word(1'b1, 1'b0, 8'd0);
    plan_word(1'b1, 1'b0, 8'd0);
    // full depth with junk upper bits; LFO peak drives the factor into saturation
    plan_cfg(sov_pkg::REG_VIB_DEPTH, 32'hFFFF_F960);
    plan_cfg(sov_pkg::REG_VIB_INC, 32'h4000_0000);
    repeat (4) plan_word(1'b1, 1'b0, 8'd0);
    plan_cfg(sov_pkg::REG_VIB_DEPTH, 32'h0000_0FFF);
    repeat (3) plan_word(1'b1, 1'b0, 8'd0);
    plan_cfg(UNMAPPED_REG, 32'hFFFF_FFFF);
    repeat (2) plan_word(1'b1, 1'b0, 8'd0);
    plan_cfg(sov_pkg::REG_VIB_DEPTH, 32'h0000_0000);
    repeat (2) plan_word(1'b1, 1'b0, 8'd0);
    plan_cfg(sov_pkg::REG_VIB_INC, 32'hFFFF_FFFF);
    plan_cfg(sov_pkg::REG_NOTE_INC, 32'h0000_0000);
    repeat (2) plan_word(1'b1, 1'b0, 8'd0);
    plan_cfg(sov_pkg::REG_VIB_INC, 32'h0000_0000);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[n]) begin
      if (script[n].kind == ROW_CFG) begin
        wait_idle();
        cfg_write(script[n].sel, script[n].data);
      end else begin
        put_word(script[n].tick, script[n].typed, script[n].level);
      end
    end

    phase      = 0;
    words_done = 0;
    while (words_done < WORD_TARGET) begin
      wait_idle();
      phase++;
      idle_on = ($urandom_range(5) != 0);

      case ($urandom_range(4))
        0:       value = $urandom;
        1:       value = $urandom_range(32'h0100_0000);
        2:       value = 32'h0000_0000;
        3:       value = 32'hFFFF_FFFF;
        default: value = $urandom_range(32'h0800_0000, 32'h0010_0000);
      endcase
      cfg_write(sov_pkg::REG_NOTE_INC, value);

      case ($urandom_range(4))
        0:       cents = 12'd0;
        1:       cents = 12'(DEPTH_CAP);
        2:       cents = 12'hFFF;
        3:       cents = 12'($urandom_range(DEPTH_CAP));
        default: cents = 12'($urandom_range(4095));
      endcase
      junk = $urandom;
      cfg_write(sov_pkg::REG_VIB_DEPTH, {junk[31:12], cents});

      case ($urandom_range(3))
        0:       value = 32'h0000_0000;
        1:       value = $urandom;
        2:       value = $urandom_range(32'h1000_0000, 32'h0040_0000);
        default: value = 32'hFFFF_FFFF;
      endcase
      cfg_write(sov_pkg::REG_VIB_INC, value);

      if ($urandom_range(4) == 0) begin
        cfg_write(UNMAPPED_REG, $urandom);
      end

      count = $urandom_range(60, 20);
      if (phase == 2) begin
        // long stretch with no gaps on either side
        idle_on = 1'b0;
        count   = 200;
      end
      if (phase == 4) begin
        // hold the receiver while words keep coming, so the input backs up
        idle_on  = 1'b0;
        hold_len = HOLD_CYC;
        hold_seq++;
        count    = 60;
      end

      for (int n = 0; n < count; n++) begin
        tick = ($urandom_range(99) >= 8);
        put_word(tick, 1'b0, 8'd0);
        words_done++;
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
